// File: hw/rtl/picture_command_stream_decoder_defines.svh
// Assertion macros shared by the picture command stream decoder.
`ifndef PICTURE_COMMAND_STREAM_DECODER_DEFINES_SVH
`define PICTURE_COMMAND_STREAM_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PCSD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pcsd_pkg.sv
// Types and constants of the picture command stream decoder.
package pcsd_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_PICCOL  = 4'd1,
    MODE_PRICOL  = 4'd2,
    MODE_BRUSH   = 4'd3,
    MODE_YCORNER = 4'd4,
    MODE_XCORNER = 4'd5,
    MODE_ABSLINE = 4'd6,
    MODE_RELLINE = 4'd7,
    MODE_FILL    = 4'd8,
    MODE_PLOT    = 4'd9,
    MODE_DONE    = 4'd10
  } mode_e;

  typedef enum logic [3:0] {
    KIND_LINE    = 4'd0,
    KIND_FILL    = 4'd1,
    KIND_PLOT    = 4'd2,
    KIND_PICCOL  = 4'd3,
    KIND_PICOFF  = 4'd4,
    KIND_PRICOL  = 4'd5,
    KIND_PRIOFF  = 4'd6,
    KIND_BRUSH   = 4'd7,
    KIND_END     = 4'd8,
    KIND_UNKNOWN = 4'd9
  } kind_e;

  localparam logic [7:0] CMD_FIRST     = 8'hF0;
  localparam logic [7:0] CMD_PIC_COLOR = 8'hF0;
  localparam logic [7:0] CMD_PIC_OFF   = 8'hF1;
  localparam logic [7:0] CMD_PRI_COLOR = 8'hF2;
  localparam logic [7:0] CMD_PRI_OFF   = 8'hF3;
  localparam logic [7:0] CMD_Y_CORNER  = 8'hF4;
  localparam logic [7:0] CMD_X_CORNER  = 8'hF5;
  localparam logic [7:0] CMD_ABS_LINE  = 8'hF6;
  localparam logic [7:0] CMD_REL_LINE  = 8'hF7;
  localparam logic [7:0] CMD_FILL      = 8'hF8;
  localparam logic [7:0] CMD_BRUSH     = 8'hF9;
  localparam logic [7:0] CMD_PLOT      = 8'hFA;
  localparam logic [7:0] CMD_END       = 8'hFF;

  localparam logic [7:0] REL_DX_MASK    = 8'h70;
  localparam logic [7:0] REL_DX_NEG     = 8'h80;
  localparam logic [7:0] REL_DY_NEG     = 8'h08;
  localparam logic [7:0] BRUSH_SPLATTER = 8'h20;

  localparam int unsigned OUT_TDATA_W = 72;

  typedef struct packed {
    logic       picture_start;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    kind_e      command_kind;
    logic [7:0] start_x;
    logic [7:0] start_y;
    logic [7:0] end_x;
    logic [7:0] end_y;
    logic [7:0] pattern_value;
    logic       picture_on;
    logic [7:0] picture_shade;
    logic       priority_on;
    logic [7:0] priority_shade;
    logic [7:0] brush_setting;
  } result_t;

endpackage

// File: hw/rtl/pcsd_in_stage.sv
// Input register of the picture command stream decoder.
module pcsd_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  pcsd_pkg::in_item_t item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output pcsd_pkg::in_item_t item_o
);
  import pcsd_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  // The register frees up in the same cycle that its item moves on.
  assign ready_o = !valid_q || advance_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: hw/rtl/pcsd_core.sv
// Parser state and single-byte command decode of the picture command stream decoder.
module pcsd_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  pcsd_pkg::in_item_t item_i,
  output logic               emit_o,
  output pcsd_pkg::result_t  res_o
);
  import pcsd_pkg::*;

  mode_e      mode_q, mode_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] pen_x_q, pen_x_d;
  logic [7:0] pen_y_q, pen_y_d;
  logic [7:0] held_arg_q, held_arg_d;
  logic [7:0] held_pat_q, held_pat_d;
  logic [7:0] brush_q, brush_d;
  logic       pic_en_q, pic_en_d;
  logic [7:0] pic_col_q, pic_col_d;
  logic       pri_en_q, pri_en_d;
  logic [7:0] pri_col_q, pri_col_d;

  logic [7:0] b;
  logic       do_cmd;
  logic       y_move;
  logic [7:0] nx, ny;
  kind_e      kind;
  logic [7:0] sx, sy, ex, ey, pat;

  function automatic logic [7:0] sat_step(input logic [7:0] base, input logic [2:0] mag,
                                          input logic neg);
    logic [8:0] sum;
    logic [7:0] res;
    sum = {1'b0, base} + {6'b0, mag};
    if (neg) begin
      res = (base < {5'b0, mag}) ? 8'd0 : (base - {5'b0, mag});
    end else begin
      res = sum[8] ? 8'hFF : sum[7:0];
    end
    return res;
  endfunction

  assign b = item_i.stream_byte;

  always_comb begin
    // Start from the state, or from the reset state on the first byte of a picture.
    if (item_i.picture_start) begin
      mode_d = MODE_IDLE;
      phase_d = 2'd0;
      pen_x_d = 8'd0;
      pen_y_d = 8'd0;
      held_arg_d = 8'd0;
      held_pat_d = 8'd0;
      brush_d = 8'd0;
      pic_en_d = 1'b0;
      pic_col_d = 8'd0;
      pri_en_d = 1'b0;
      pri_col_d = 8'd0;
    end else begin
      mode_d = mode_q;
      phase_d = phase_q;
      pen_x_d = pen_x_q;
      pen_y_d = pen_y_q;
      held_arg_d = held_arg_q;
      held_pat_d = held_pat_q;
      brush_d = brush_q;
      pic_en_d = pic_en_q;
      pic_col_d = pic_col_q;
      pri_en_d = pri_en_q;
      pri_col_d = pri_col_q;
    end

    emit_o = 1'b0;
    do_cmd = 1'b0;
    kind = KIND_LINE;
    sx = 8'd0;
    sy = 8'd0;
    ex = 8'd0;
    ey = 8'd0;
    pat = 8'd0;
    y_move = 1'b0;
    nx = 8'd0;
    ny = 8'd0;

    case (mode_d)
      MODE_DONE: begin
      end
      MODE_PICCOL: begin
        mode_d = MODE_IDLE;
        pic_en_d = 1'b1;
        pic_col_d = b;
        emit_o = 1'b1;
        kind = KIND_PICCOL;
      end
      MODE_PRICOL: begin
        mode_d = MODE_IDLE;
        pri_en_d = 1'b1;
        pri_col_d = b;
        emit_o = 1'b1;
        kind = KIND_PRICOL;
      end
      MODE_BRUSH: begin
        mode_d = MODE_IDLE;
        brush_d = b;
        emit_o = 1'b1;
        kind = KIND_BRUSH;
      end
      MODE_FILL: begin
        if (b >= CMD_FIRST) begin
          do_cmd = 1'b1;
        end else if (phase_d == 2'd0) begin
          held_arg_d = b;
          phase_d = 2'd1;
        end else begin
          phase_d = 2'd0;
          emit_o = 1'b1;
          kind = KIND_FILL;
          sx = held_arg_d;
          sy = b;
        end
      end
      MODE_PLOT: begin
        if (b >= CMD_FIRST) begin
          do_cmd = 1'b1;
        end else if (phase_d == 2'd0) begin
          if ((brush_d & BRUSH_SPLATTER) != 8'd0) begin
            held_pat_d = b;
            phase_d = 2'd1;
          end else begin
            held_pat_d = 8'd0;
            held_arg_d = b;
            phase_d = 2'd2;
          end
        end else if (phase_d == 2'd1) begin
          held_arg_d = b;
          phase_d = 2'd2;
        end else begin
          phase_d = 2'd0;
          emit_o = 1'b1;
          kind = KIND_PLOT;
          sx = held_arg_d;
          sy = b;
          pat = held_pat_d;
        end
      end
      MODE_YCORNER, MODE_XCORNER, MODE_ABSLINE, MODE_RELLINE: begin
        if (b >= CMD_FIRST) begin
          do_cmd = 1'b1;
        end else if (phase_d == 2'd0) begin
          pen_x_d = b;
          phase_d = 2'd1;
        end else if (phase_d == 2'd1) begin
          pen_y_d = b;
          phase_d = 2'd2;
        end else begin
          if (mode_d == MODE_ABSLINE) begin
            if (phase_d == 2'd2) begin
              held_arg_d = b;
              phase_d = 2'd3;
            end else begin
              phase_d = 2'd2;
              emit_o = 1'b1;
              nx = held_arg_d;
              ny = b;
            end
          end else if (mode_d == MODE_RELLINE) begin
            phase_d = 2'd2;
            emit_o = 1'b1;
            nx = sat_step(pen_x_d, b[6:4] & REL_DX_MASK[6:4], (b & REL_DX_NEG) != 8'd0);
            ny = sat_step(pen_y_d, b[2:0], (b & REL_DY_NEG) != 8'd0);
          end else begin
            // Corner lines alternate between a vertical and a horizontal move.
            y_move = (mode_d == MODE_YCORNER) == (phase_d == 2'd2);
            phase_d = (phase_d == 2'd2) ? 2'd3 : 2'd2;
            emit_o = 1'b1;
            nx = y_move ? pen_x_d : b;
            ny = y_move ? b : pen_y_d;
          end
          if (emit_o) begin
            kind = KIND_LINE;
            sx = pen_x_d;
            sy = pen_y_d;
            ex = nx;
            ey = ny;
            pen_x_d = nx;
            pen_y_d = ny;
          end
        end
      end
      default: begin
        do_cmd = 1'b1;
      end
    endcase

    // A command byte, or a data byte outside a command, is decoded here.
    if (do_cmd) begin
      mode_d = MODE_IDLE;
      phase_d = 2'd0;
      if (b >= CMD_FIRST) begin
        case (b)
          CMD_PIC_COLOR: mode_d = MODE_PICCOL;
          CMD_PIC_OFF: begin
            pic_en_d = 1'b0;
            emit_o = 1'b1;
            kind = KIND_PICOFF;
          end
          CMD_PRI_COLOR: mode_d = MODE_PRICOL;
          CMD_PRI_OFF: begin
            pri_en_d = 1'b0;
            emit_o = 1'b1;
            kind = KIND_PRIOFF;
          end
          CMD_Y_CORNER: mode_d = MODE_YCORNER;
          CMD_X_CORNER: mode_d = MODE_XCORNER;
          CMD_ABS_LINE: mode_d = MODE_ABSLINE;
          CMD_REL_LINE: mode_d = MODE_RELLINE;
          CMD_FILL:     mode_d = MODE_FILL;
          CMD_BRUSH:    mode_d = MODE_BRUSH;
          CMD_PLOT:     mode_d = MODE_PLOT;
          CMD_END: begin
            mode_d = MODE_DONE;
            emit_o = 1'b1;
            kind = KIND_END;
          end
          default: begin
            emit_o = 1'b1;
            kind = KIND_UNKNOWN;
            pat = b;
          end
        endcase
      end
    end

    res_o.command_kind   = kind;
    res_o.start_x        = sx;
    res_o.start_y        = sy;
    res_o.end_x          = ex;
    res_o.end_y          = ey;
    res_o.pattern_value  = pat;
    res_o.picture_on     = pic_en_d;
    res_o.picture_shade  = pic_col_d;
    res_o.priority_on    = pri_en_d;
    res_o.priority_shade = pri_col_d;
    res_o.brush_setting  = brush_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      phase_q <= 2'd0;
      pen_x_q <= 8'd0;
      pen_y_q <= 8'd0;
      held_arg_q <= 8'd0;
      held_pat_q <= 8'd0;
      brush_q <= 8'd0;
      pic_en_q <= 1'b0;
      pic_col_q <= 8'd0;
      pri_en_q <= 1'b0;
      pri_col_q <= 8'd0;
    end else if (take_i) begin
      mode_q <= mode_d;
      phase_q <= phase_d;
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      held_arg_q <= held_arg_d;
      held_pat_q <= held_pat_d;
      brush_q <= brush_d;
      pic_en_q <= pic_en_d;
      pic_col_q <= pic_col_d;
      pri_en_q <= pri_en_d;
      pri_col_q <= pri_col_d;
    end
  end

endmodule

// File: hw/rtl/pcsd_out_stage.sv
// Result register of the picture command stream decoder.
module pcsd_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              emit_i,
  input  pcsd_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              valid_o,
  input  logic              ready_i,
  output pcsd_pkg::result_t res_o
);
  import pcsd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = emit_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// File: hw/rtl/picture_command_stream_decoder.sv
// A byte goes from the input register, through the decoder, into the result register.
// Throughput: one byte per cycle unless stalled; each byte is decoded in one pass between the
// input register and the result register, and parser state updates as it goes.
// A result not taken holds the result register and, once the input register is
// also full, stalls the input side. Reset clears parser, pen, colors and both
// valid flags at once; no clearing sweep is needed.
`include "picture_command_stream_decoder_defines.svh"

module picture_command_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream: one picture resource byte per transaction.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] stream_byte
  input  logic        s_axis_tuser_i,   // [0] picture_start
  // Result stream: one decoded command per transaction.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [7:0] start_x, [15:8] start_y, [23:16] end_x,
                                        // [31:24] end_y, [39:32] pattern_value,
                                        // [40] picture_on, [48:41] picture_shade,
                                        // [49] priority_on, [57:50] priority_shade,
                                        // [65:58] brush_setting, [71:66] zero
  output logic [3:0]  m_axis_tuser_o    // [3:0] command_kind
);
  import pcsd_pkg::*;

  in_item_t in_item;
  in_item_t stage_item;
  logic     stage_valid;
  logic     can_load;
  logic     advance;
  logic     core_emit;
  result_t  core_res;
  result_t  out_res;

  assign in_item.stream_byte   = s_axis_tdata_i;
  assign in_item.picture_start = s_axis_tuser_i;

  // A byte moves from the input register through the decoder whenever the
  // result register is free or is being emptied in this cycle.
  assign advance = stage_valid && can_load;

  pcsd_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  pcsd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (advance),
    .item_i (stage_item),
    .emit_o (core_emit),
    .res_o  (core_res)
  );

  pcsd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .emit_i     (core_emit),
    .res_i      (core_res),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid_o),
    .ready_i    (m_axis_tready_i),
    .res_o      (out_res)
  );

  // Fields are packed from the lowest bit up, padded to whole bytes.
  assign m_axis_tdata_o = {6'd0,
                           out_res.brush_setting,
                           out_res.priority_shade,
                           out_res.priority_on,
                           out_res.picture_shade,
                           out_res.picture_on,
                           out_res.pattern_value,
                           out_res.end_y,
                           out_res.end_x,
                           out_res.start_y,
                           out_res.start_x};
  assign m_axis_tuser_o = out_res.command_kind;

  // Both registers full and the result stalled: no further byte may enter.
  `PCSD_ASSERT_IMPL(a_stall_blocks_input, stage_valid && m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "input taken while pipeline is stalled")
  // An accepted byte is held in the input register on the next cycle.
  `PCSD_ASSERT_NEXT(a_accept_fills_stage, s_axis_tvalid_i && s_axis_tready_o, stage_valid, "accepted byte lost")
  // Only line results carry an end point.
  `PCSD_ASSERT_IMPL(a_end_point_only_line, m_axis_tvalid_o && (out_res.command_kind != KIND_LINE), (out_res.end_x == 8'd0) && (out_res.end_y == 8'd0), "end point on a non-line result")

endmodule
